// ===== rtl/pds_pkg.sv =====
// Shared widths, constants and the pipeline stage type of the pairwise distance score unit.
package pds_pkg;

   localparam int CoordW   = 25;
   localparam int AbsW     = 25;
   localparam int SqW      = 50;
   localparam int SumW     = 52;
   localparam int D0W      = 20;
   localparam int D0SqW    = 40;
   localparam int DenW     = 53;
   localparam int DivW     = 54;
   localparam int RootW    = 26;
   localparam int RemW     = 29;
   localparam int DistW    = 25;
   localparam int SimW     = 17;
   localparam int Iters    = 26;
   localparam int DivSteps = 17;
   localparam int ReqDataW = 152;
   localparam int RspDataW = 48;

   localparam logic [D0SqW-1:0] D0SqReset = 40'd9000000;
   localparam logic [DistW-1:0] DistMax   = 25'h1FFFFFF;
   localparam logic [SimW-1:0]  SimOne    = 17'h10000;

   typedef struct packed {
      logic                valid;
      logic [SumW-1:0]     rad;
      logic [RemW-1:0]     rem;
      logic [RootW-1:0]    root;
      logic [DivW-1:0]     dvs;
      logic [DivW-1:0]     drem;
      logic [DivSteps-1:0] dnum;
      logic [SimW-1:0]     quo;
      logic                dzero;
   } stage_type;

endpackage

// ===== rtl/pds_core.sv =====
// Pipelined datapath: coordinate differences, squares, square root and quotient per word.
module pds_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [pds_pkg::CoordW-1:0]  first_x,
   input  logic [pds_pkg::CoordW-1:0]  first_y,
   input  logic [pds_pkg::CoordW-1:0]  first_z,
   input  logic [pds_pkg::CoordW-1:0]  second_x,
   input  logic [pds_pkg::CoordW-1:0]  second_y,
   input  logic [pds_pkg::CoordW-1:0]  second_z,
   input  logic [pds_pkg::D0SqW-1:0]   d0sq,
   output logic                        out_valid,
   output logic [pds_pkg::DistW-1:0]   distance,
   output logic [pds_pkg::SimW-1:0]    similarity
);
   import pds_pkg::*;

   logic [AbsW-1:0]  absx_ff, absy_ff, absz_ff;
   logic [AbsW-1:0]  absx_in, absy_in, absz_in;
   logic [SqW-1:0]   sqx_ff, sqy_ff, sqz_ff;
   logic [SumW-1:0]  sum_ff, sum_in;
   logic [SumW-1:0]  sum4_ff;
   logic [DenW-1:0]  den_ff, den_in;
   logic [D0SqW-1:0] d0sq1_ff, d0sq2_ff, d0sq3_ff, d0sq4_ff;
   logic             v1_ff, v2_ff, v3_ff, v4_ff;
   stage_type        st_ff [0:Iters];
   stage_type        st_in [0:Iters];
   logic [RemW-1:0]  rem_sh [1:Iters];
   logic [RemW-1:0]  trial [1:Iters];
   logic [DivW:0]    drem_sh [1:Iters];
   logic [DivW:0]    ddiff [1:Iters];
   logic             round_up;
   logic [RootW:0]   rounded;
   logic             out_valid_ff;
   logic [DistW-1:0] dist_ff, dist_in;
   logic [SimW-1:0]  sim_ff, sim_in;

   function automatic logic [AbsW-1:0] abs_diff(input logic [CoordW-1:0] a,
                                                input logic [CoordW-1:0] b);
      logic signed [CoordW:0] d;
      d = $signed({b[CoordW-1], b}) - $signed({a[CoordW-1], a});
      if (d[CoordW]) begin
         d = -d;
      end
      return d[AbsW-1:0];
   endfunction

   assign absx_in = abs_diff(first_x, second_x);
   assign absy_in = abs_diff(first_y, second_y);
   assign absz_in = abs_diff(first_z, second_z);
   assign sum_in  = SumW'(sqx_ff) + SumW'(sqy_ff) + SumW'(sqz_ff);
   assign den_in  = DenW'(d0sq3_ff) + DenW'(sum_ff);

   always_comb begin
      st_in[0].valid = v4_ff;
      st_in[0].rad   = sum4_ff;
      st_in[0].rem   = '0;
      st_in[0].root  = '0;
      st_in[0].dvs   = {den_ff, 1'b0};
      st_in[0].drem  = DivW'(d0sq4_ff) + DivW'(den_ff[DenW-1:DivSteps]);
      st_in[0].dnum  = den_ff[DivSteps-1:0];
      st_in[0].quo   = '0;
      st_in[0].dzero = (den_ff == '0);
      for (int k = 1; k <= Iters; k++) begin
         st_in[k] = st_ff[k-1];
         rem_sh[k] = {st_ff[k-1].rem[RemW-3:0], st_ff[k-1].rad[SumW-1:SumW-2]};
         trial[k] = {1'b0, st_ff[k-1].root, 2'b01};
         st_in[k].rad = {st_ff[k-1].rad[SumW-3:0], 2'b00};
         if (rem_sh[k] >= trial[k]) begin
            st_in[k].rem  = rem_sh[k] - trial[k];
            st_in[k].root = {st_ff[k-1].root[RootW-2:0], 1'b1};
         end else begin
            st_in[k].rem  = rem_sh[k];
            st_in[k].root = {st_ff[k-1].root[RootW-2:0], 1'b0};
         end
         drem_sh[k] = {st_ff[k-1].drem, st_ff[k-1].dnum[DivSteps-1]};
         ddiff[k] = drem_sh[k] - {1'b0, st_ff[k-1].dvs};
         if (k <= DivSteps) begin
            st_in[k].dnum = {st_ff[k-1].dnum[DivSteps-2:0], 1'b0};
            if (drem_sh[k] >= {1'b0, st_ff[k-1].dvs}) begin
               st_in[k].drem = ddiff[k][DivW-1:0];
               st_in[k].quo  = {st_ff[k-1].quo[SimW-2:0], 1'b1};
            end else begin
               st_in[k].drem = drem_sh[k][DivW-1:0];
               st_in[k].quo  = {st_ff[k-1].quo[SimW-2:0], 1'b0};
            end
         end
      end
   end

   assign round_up = st_ff[Iters].rem > RemW'(st_ff[Iters].root);
   assign rounded  = (RootW+1)'(st_ff[Iters].root) + (RootW+1)'(round_up);
   assign dist_in  = (rounded > (RootW+1)'(DistMax)) ? DistMax : rounded[DistW-1:0];
   assign sim_in   = st_ff[Iters].dzero ? SimOne : st_ff[Iters].quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k <= Iters; k++) begin
            st_ff[k].valid <= 1'b0;
         end
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         out_valid_ff <= st_ff[Iters].valid;
         for (int k = 0; k <= Iters; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         absx_ff  <= absx_in;
         absy_ff  <= absy_in;
         absz_ff  <= absz_in;
         d0sq1_ff <= d0sq;
         sqx_ff   <= SqW'(absx_ff) * SqW'(absx_ff);
         sqy_ff   <= SqW'(absy_ff) * SqW'(absy_ff);
         sqz_ff   <= SqW'(absz_ff) * SqW'(absz_ff);
         d0sq2_ff <= d0sq1_ff;
         sum_ff   <= sum_in;
         d0sq3_ff <= d0sq2_ff;
         den_ff   <= den_in;
         sum4_ff  <= sum_ff;
         d0sq4_ff <= d0sq3_ff;
         dist_ff  <= dist_in;
         sim_ff   <= sim_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign distance   = dist_ff;
   assign similarity = sim_ff;

endmodule

// ===== rtl/pairwise_distance_score_unit.sv =====
// Top level of the pairwise distance score unit: stream ports, scale register and datapath.
//
//   channel   direction  width  contents
//   req       in         152    first_x, first_y, first_z, second_x, second_y, second_z
//   rsp       out        48     distance, similarity
//   csr       in         20     d0_scale
//
// One word is accepted per cycle while the result register is empty or being taken;
// the pipeline runs the 26 square root steps, one per pipeline stage, with the
// 17 quotient steps running alongside them.
// Reset is synchronous and clears the valid bits and sets the squared d0_scale register to 3000 squared.
// When the result register is full and not taken, the whole pipeline holds.
module pairwise_distance_score_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // first_x, first_y, first_z, second_x, second_y, second_z, zero pad
   input  logic [pds_pkg::ReqDataW-1:0]   req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // distance, similarity, zero pad
   output logic [pds_pkg::RspDataW-1:0]   rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pds_pkg::D0W-1:0]        csr_data
);
   import pds_pkg::*;

   logic [D0SqW-1:0] d0sq_ff;
   logic             advance;
   logic [DistW-1:0] distance;
   logic [SimW-1:0]  similarity;

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         d0sq_ff <= D0SqReset;
      end else if (csr_valid) begin
         d0sq_ff <= D0SqW'(csr_data) * D0SqW'(csr_data);
      end
   end

   pds_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_tvalid),
      .first_x    (req_tdata[24:0]),
      .first_y    (req_tdata[49:25]),
      .first_z    (req_tdata[74:50]),
      .second_x   (req_tdata[99:75]),
      .second_y   (req_tdata[124:100]),
      .second_z   (req_tdata[149:125]),
      .d0sq       (d0sq_ff),
      .out_valid  (rsp_tvalid),
      .distance   (distance),
      .similarity (similarity)
   );

   assign rsp_tdata = {6'b0, similarity, distance};

endmodule

// ===== test/tb_pairwise_distance_score_unit.sv =====
// Testbench for the pairwise distance score unit: random and directed atom pairs checked against a predictor.
module tb_pairwise_distance_score_unit;
   import pds_pkg::*;

   typedef struct {
      logic [DistW-1:0] distance;
      logic [SimW-1:0]  similarity;
   } score_type;

   class score_board_type;
      score_type   pending[$];
      logic [19:0] scale;
      int          errors;
      int          checked;

      function new();
         scale = 20'd3000;
         errors = 0;
         checked = 0;
      endfunction

      function void note_pair(logic [ReqDataW-1:0] word);
         logic signed [63:0] dx, dy, dz;
         logic [127:0]       sum, r, bitv, v, d0sq, den, sim;
         score_type          s;
         dx = 64'(signed'(word[99:75])) - 64'(signed'(word[24:0]));
         dy = 64'(signed'(word[124:100])) - 64'(signed'(word[49:25]));
         dz = 64'(signed'(word[149:125])) - 64'(signed'(word[74:50]));
         sum = 128'(dx * dx) + 128'(dy * dy) + 128'(dz * dz);
         v = sum;
         r = 0;
         bitv = 128'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= r + bitv) begin
               v -= r + bitv;
               r = (r >> 1) + bitv;
            end else begin
               r >>= 1;
            end
            bitv >>= 2;
         end
         if (sum - r * r > r) r += 1;
         s.distance = (r > 128'h1FFFFFF) ? DistMax : r[24:0];
         d0sq = 128'(scale) * 128'(scale);
         den = d0sq + sum;
         if (den == 0) sim = 128'h10000;
         else sim = (2 * d0sq * 128'h10000 + den) / (2 * den);
         s.similarity = sim[16:0];
         pending.push_back(s);
      endfunction

      function void check_result(logic [RspDataW-1:0] word);
         score_type e;
         if (pending.size() == 0) begin
            $error("unexpected result word %h", word);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (word[24:0] !== e.distance) begin
            $error("distance: expected %0d, got %0d", e.distance, word[24:0]);
            errors++;
         end
         if (word[41:25] !== e.similarity) begin
            $error("similarity: expected %0d, got %0d", e.similarity, word[41:25]);
            errors++;
         end
      endfunction
   endclass

   logic                clock = 0;
   logic                reset = 1;
   logic                req_tvalid = 0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                csr_valid = 0;
   logic                csr_ready;
   logic [D0W-1:0]      csr_data = '0;

   score_board_type board = new();
   int  send_idle = 0;
   int  recv_idle = 0;
   int  hold_off = 0;
   int  cycles = 0;
   int  sent = 0;
   int  cfg_writes = 0;

   always #10 clock = ~clock;

   pairwise_distance_score_unit i_dut (.*);

   always @(posedge clock) begin
      cycles++;
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
      if (cycles > 400000) begin
         $display("** pairwise_distance_score_unit: FAILED **");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   function automatic logic [24:0] rand_coord();
      case ($urandom_range(5))
         0: return 25'(-1000000);
         1: return 25'd9999999;
         2: return 25'($urandom);
         3: return 25'($urandom_range(2000) - 1000);
         default: return 25'($urandom_range(10999999) - 1000000);
      endcase
   endfunction

   task automatic send_pair(logic [24:0] ax, ay, az, bx, by, bz);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata <= {2'b0, bz, by, bx, az, ay, ax};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_pair({2'b0, bz, by, bx, az, ay, ax});
      sent++;
      @(negedge clock);
   endtask

   task automatic send_random(int count);
      logic [24:0] ax, ay, az;
      repeat (count) begin
         ax = rand_coord();
         ay = rand_coord();
         az = rand_coord();
         if ($urandom_range(9) == 0) send_pair(ax, ay, az, ax, ay, az);
         else if ($urandom_range(3) == 0)
            send_pair(ax, ay, az, ax + 25'($urandom_range(20000)) - 25'd10000,
                      ay + 25'($urandom_range(400)), az - 25'($urandom_range(9000)));
         else send_pair(ax, ay, az, rand_coord(), rand_coord(), rand_coord());
      end
   endtask

   task automatic write_scale(logic [19:0] value);
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.scale = value;
      cfg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_pair('0, '0, '0, '0, '0, '0);
      send_pair(25'(-1000000), 25'(-1000000), 25'(-1000000), 25'd9999999, 25'd9999999,
                25'd9999999);
      send_pair(25'h1000000, 25'h1000000, 25'h1000000, 25'hFFFFFF, 25'hFFFFFF, 25'hFFFFFF);
      send_pair(25'hFFFFFF, 25'h1000000, 25'd0, 25'h1000000, 25'hFFFFFF, 25'h1FFFFFF);
      send_pair(25'd0, 25'd0, 25'd0, 25'd3000, 25'd0, 25'd0);
      send_pair(25'd1, 25'd2, 25'd3, 25'd2, 25'd3, 25'd4);
      send_pair(25'h1555555, 25'h0AAAAAA, 25'd7, 25'h0AAAAAA, 25'h1555555, 25'd8);
      write_scale(20'd0);
      send_pair(25'd5, 25'd5, 25'd5, 25'd5, 25'd5, 25'd5);
      send_pair(25'd5, 25'd5, 25'd5, 25'd6, 25'd5, 25'd5);
      send_random(30);
      write_scale(20'hFFFFF);
      send_pair(25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd1);
      send_random(30);
      write_scale(20'd1);
      send_pair(25'd0, 25'd0, 25'd0, 25'd1, 25'd0, 25'd0);
      send_random(30);
      write_scale(20'd3000);
      send_idle = 15;
      recv_idle = 60;
      send_random(180);
      write_scale(20'($urandom_range(1000000, 1)));
      send_idle = 60;
      recv_idle = 15;
      send_random(180);
      send_idle = 0;
      recv_idle = 0;
      hold_off = 300;
      send_random(200);
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      $display("Sent %0d atom pairs, checked %0d results across %0d scale settings.",
               sent, board.checked, cfg_writes + 1);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("** pairwise_distance_score_unit: PASSED **");
      else
         $display("** pairwise_distance_score_unit: FAILED **");
      $finish;
   end
endmodule

// ===== pairwise_distance_score_unit.f =====
rtl/pds_pkg.sv
rtl/pds_core.sv
rtl/pairwise_distance_score_unit.sv
test/tb_pairwise_distance_score_unit.sv
